// ===== hw/rtl/window_median_filter_core_macros.svh =====
// Assertion macros used by the checker file of the window median filter.
// No dependencies; included by bare file name.
`ifndef WINDOW_MEDIAN_FILTER_CORE_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define WMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmf assertion failed");

// next-cycle implication
`define WMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmf assertion failed");

`endif

// ===== hw/rtl/wmf_pkg.sv =====
// Shared constants, codes and types of the window median filter.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package wmf_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int MAX_WINDOW = 8;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int FRAME_W = ROW_W + 1;
    localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int K_W     = 4;
    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int BIT_W   = $clog2(PIX_W);
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam int RESET_ROWS   = 256;
    localparam int RESET_COLS   = 256;
    localparam int RESET_WINDOW = 4;
    localparam int MIN_WINDOW   = 2;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS  = 2'd0,
        REG_FRAME_COLS  = 2'd1,
        REG_WINDOW_SIZE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic             sample_valid;
        logic             sample_last;
        logic [BIT_W-1:0] bit_idx;
        logic [CNT_W-1:0] rank_init;
    } sel_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wmf_select.sv =====
// Bitwise radix selection unit: finds the pixel of a given rank, one result bit per pass.
// Depends on wmf_pkg.
`default_nettype none

module wmf_select (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire wmf_pkg::sel_ctl_t         ctl,
    input  wire logic [wmf_pkg::PIX_W-1:0] sample,
    output logic      [wmf_pkg::PIX_W-1:0] value
);

    logic [wmf_pkg::PIX_W-1:0] prefix_reg, prefix_next;
    logic [wmf_pkg::CNT_W-1:0] rank_reg, rank_next;
    logic [wmf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [wmf_pkg::PIX_W-1:0] low_ones;
    logic [wmf_pkg::PIX_W-1:0] hi_mask;
    logic                      match;
    logic [wmf_pkg::CNT_W-1:0] count_sum;

    // bits above the current one must equal the decided prefix
    assign low_ones  = (wmf_pkg::PIX_W'(2) << ctl.bit_idx) - wmf_pkg::PIX_W'(1);
    assign hi_mask   = ~low_ones;
    assign match     = ctl.sample_valid && (((sample ^ prefix_reg) & hi_mask) == '0)
                       && !sample[ctl.bit_idx];
    assign count_sum = count_reg + wmf_pkg::CNT_W'(match);

    always_comb
    begin
        prefix_next = prefix_reg;
        rank_next   = rank_reg;
        count_next  = count_reg;
        if (ctl.start)
        begin
            prefix_next = '0;
            rank_next   = ctl.rank_init;
            count_next  = '0;
        end
        else if (ctl.sample_valid)
        begin
            if (ctl.sample_last)
            begin
                count_next = '0;
                if (rank_reg >= count_sum)
                begin
                    prefix_next[ctl.bit_idx] = 1'b1;
                    rank_next = rank_reg - count_sum;
                end
            end
            else
            begin
                count_next = count_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            rank_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            rank_reg   <= rank_next;
            count_reg  <= count_next;
        end
    end

    assign value = prefix_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/window_median_filter_core.sv =====
// Window median filter over a stored 8-bit frame: write beats store pixels, read beats
// return the median of the k-by-k window (offsets -1..k-2), the copied source pixel, or
// zero flagged out of range. A median read is paced by the single frame-store read port,
// which is scanned once per result bit while wmf_select decides that bit. The block takes
// no beat during a read; a finished result waits in the output register while the next
// beat is taken.
// Depends on wmf_pkg and wmf_select.
`default_nettype none

module window_median_filter_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [wmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wmf_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [7:0]                        row,
    input  wire logic [7:0]                        col,
    input  wire logic [7:0]                        pixel_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [7:0]                        filtered_value,
    output logic                                   out_of_range
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_COPY   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_FINISH = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [wmf_pkg::FRAME_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [wmf_pkg::K_W-1:0]     win_cfg_reg;

    logic [wmf_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [wmf_pkg::COL_W-1:0]   col_reg, col_next;
    logic [wmf_pkg::K_W-1:0]     k_reg, k_next;
    logic [wmf_pkg::IDX_W-1:0]   dr_reg, dr_next;
    logic [wmf_pkg::IDX_W-1:0]   dc_reg, dc_next;
    logic [wmf_pkg::BIT_W-1:0]   bit_reg, bit_next;
    logic                        issue_reg, issue_next;
    logic                        last_issue_reg, last_issue_next;
    logic [wmf_pkg::PIX_W-1:0]   res_value_reg, res_value_next;
    logic                        res_oor_reg, res_oor_next;
    logic                        out_valid_reg, out_valid_next;
    logic [wmf_pkg::PIX_W-1:0]   out_value_reg, out_value_next;
    logic                        out_oor_reg, out_oor_next;

    logic [wmf_pkg::PIX_W-1:0]   frame_mem [wmf_pkg::MEM_DEPTH];
    logic [wmf_pkg::PIX_W-1:0]   rd_data_reg;
    logic [wmf_pkg::ADDR_W-1:0]  mem_addr;
    logic                        mem_we;

    logic [wmf_pkg::FRAME_W-1:0] rows_eff, cols_eff;
    logic [wmf_pkg::K_W-1:0]     k_eff;
    logic [wmf_pkg::K_W-1:0]     k_m1;
    logic                        in_accept;
    logic                        in_frame;
    logic                        use_window;
    logic [wmf_pkg::FRAME_W:0]   row_plus_k, col_plus_k;
    logic [wmf_pkg::ROW_W-1:0]   scan_row;
    logic [wmf_pkg::COL_W-1:0]   scan_col;
    logic                        scan_last;
    logic [2*wmf_pkg::K_W-1:0]   k_sq;
    wmf_pkg::sel_ctl_t           sel_ctl;
    logic [wmf_pkg::PIX_W-1:0]   sel_value;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= wmf_pkg::FRAME_W'(wmf_pkg::RESET_ROWS);
            cols_cfg_reg <= wmf_pkg::FRAME_W'(wmf_pkg::RESET_COLS);
            win_cfg_reg  <= wmf_pkg::K_W'(wmf_pkg::RESET_WINDOW);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wmf_pkg::REG_FRAME_ROWS:  rows_cfg_reg <= cfg_data[wmf_pkg::FRAME_W-1:0];
                wmf_pkg::REG_FRAME_COLS:  cols_cfg_reg <= cfg_data[wmf_pkg::FRAME_W-1:0];
                wmf_pkg::REG_WINDOW_SIZE: win_cfg_reg  <= cfg_data[wmf_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    assign rows_eff = (rows_cfg_reg > wmf_pkg::FRAME_W'(wmf_pkg::MAX_ROWS))
                      ? wmf_pkg::FRAME_W'(wmf_pkg::MAX_ROWS) : rows_cfg_reg;
    assign cols_eff = (cols_cfg_reg > wmf_pkg::FRAME_W'(wmf_pkg::MAX_COLS))
                      ? wmf_pkg::FRAME_W'(wmf_pkg::MAX_COLS) : cols_cfg_reg;
    assign k_eff    = (win_cfg_reg < wmf_pkg::K_W'(wmf_pkg::MIN_WINDOW))
                      ? wmf_pkg::K_W'(wmf_pkg::MIN_WINDOW)
                      : (win_cfg_reg > wmf_pkg::K_W'(wmf_pkg::MAX_WINDOW))
                      ? wmf_pkg::K_W'(wmf_pkg::MAX_WINDOW) : win_cfg_reg;

    // input classification
    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign in_frame   = (wmf_pkg::FRAME_W'(row) < rows_eff)
                        && (wmf_pkg::FRAME_W'(col) < cols_eff);
    assign row_plus_k = (wmf_pkg::FRAME_W+1)'(row) + (wmf_pkg::FRAME_W+1)'(k_eff);
    assign col_plus_k = (wmf_pkg::FRAME_W+1)'(col) + (wmf_pkg::FRAME_W+1)'(k_eff);
    assign use_window = (row != '0) && (col != '0)
                        && (row_plus_k < (wmf_pkg::FRAME_W+1)'(rows_eff))
                        && (col_plus_k < (wmf_pkg::FRAME_W+1)'(cols_eff));
    assign k_sq       = (2*wmf_pkg::K_W)'(k_eff) * (2*wmf_pkg::K_W)'(k_eff);

    // window scan address
    assign k_m1      = k_reg - wmf_pkg::K_W'(1);
    assign scan_row  = row_reg + wmf_pkg::ROW_W'(dr_reg) - wmf_pkg::ROW_W'(1);
    assign scan_col  = col_reg + wmf_pkg::COL_W'(dc_reg) - wmf_pkg::COL_W'(1);
    assign scan_last = (dr_reg == k_m1[wmf_pkg::IDX_W-1:0])
                       && (dc_reg == k_m1[wmf_pkg::IDX_W-1:0]);

    // frame store, one port
    assign mem_we   = in_accept && (command == wmf_pkg::CMD_WRITE) && in_frame;
    assign mem_addr = (state_reg == S_IDLE)
                      ? wmf_pkg::ADDR_W'(row) * wmf_pkg::ADDR_W'(wmf_pkg::MAX_COLS)
                        + wmf_pkg::ADDR_W'(col)
                      : wmf_pkg::ADDR_W'(scan_row) * wmf_pkg::ADDR_W'(wmf_pkg::MAX_COLS)
                        + wmf_pkg::ADDR_W'(scan_col);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= pixel_value;
        end
        rd_data_reg <= frame_mem[mem_addr];
    end

    // selection unit
    always_comb
    begin
        sel_ctl.start        = in_accept && (command == wmf_pkg::CMD_READ)
                               && in_frame && use_window;
        sel_ctl.sample_valid = issue_reg;
        sel_ctl.sample_last  = last_issue_reg;
        sel_ctl.bit_idx      = bit_reg;
        sel_ctl.rank_init    = wmf_pkg::CNT_W'(k_sq >> 1);
    end

    wmf_select u_select (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (sel_ctl),
        .sample (rd_data_reg),
        .value  (sel_value)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        dr_next         = dr_reg;
        dc_next         = dc_reg;
        bit_next        = bit_reg;
        issue_next      = 1'b0;
        last_issue_next = 1'b0;
        res_value_next  = res_value_reg;
        res_oor_next    = res_oor_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_oor_next    = out_oor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (command == wmf_pkg::CMD_READ))
                begin
                    if (!in_frame)
                    begin
                        res_value_next = '0;
                        res_oor_next   = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else if (use_window)
                    begin
                        row_next   = row;
                        col_next   = col;
                        k_next     = k_eff;
                        dr_next    = '0;
                        dc_next    = '0;
                        bit_next   = wmf_pkg::BIT_W'(wmf_pkg::PIX_W - 1);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_COPY;
                    end
                end
            end
            S_COPY:
            begin
                res_value_next = rd_data_reg;
                res_oor_next   = 1'b0;
                state_next     = S_EMIT;
            end
            S_SCAN:
            begin
                issue_next      = 1'b1;
                last_issue_next = scan_last;
                if (dc_reg == k_m1[wmf_pkg::IDX_W-1:0])
                begin
                    dc_next = '0;
                    if (dr_reg == k_m1[wmf_pkg::IDX_W-1:0])
                    begin
                        dr_next    = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        dr_next = dr_reg + wmf_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    dc_next = dc_reg + wmf_pkg::IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    bit_next   = bit_reg - wmf_pkg::BIT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_FINISH:
            begin
                res_value_next = sel_value;
                res_oor_next   = 1'b0;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_oor_next   = res_oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dr_reg         <= '0;
            dc_reg         <= '0;
            bit_reg        <= '0;
            issue_reg      <= 1'b0;
            last_issue_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dr_reg         <= dr_next;
            dc_reg         <= dc_next;
            bit_reg        <= bit_next;
            issue_reg      <= issue_next;
            last_issue_reg <= last_issue_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        k_reg         <= k_next;
        res_value_reg <= res_value_next;
        res_oor_reg   <= res_oor_next;
        out_value_reg <= out_value_next;
        out_oor_reg   <= out_oor_next;
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign out_of_range   = out_oor_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wmf_checker.sv =====
// Port-level checker for window_median_filter_core, bound to the top level.
// Depends on wmf_pkg and window_median_filter_core_macros.svh.
`default_nettype none

`include "window_median_filter_core_macros.svh"

module wmf_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       command,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] filtered_value,
    input  wire logic       out_of_range
);

    // stalled result beat holds
    `WMF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(filtered_value) && $stable(out_of_range))
    // out-of-frame reads return zero
    `WMF_ASSERT_IMPLY(a_oor_zero, clk, rst_n, out_valid && out_of_range, filtered_value == 8'd0)
    // a write beat never produces a result
    `WMF_ASSERT_NEXT(a_write_silent, clk, rst_n, in_valid && in_ready && command == wmf_pkg::CMD_WRITE && !out_valid, !out_valid)
    // a read beat occupies the sequencer
    `WMF_ASSERT_NEXT(a_read_busy, clk, rst_n, in_valid && in_ready && command == wmf_pkg::CMD_READ, !in_ready)

endmodule

bind window_median_filter_core wmf_checker u_wmf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .out_of_range   (out_of_range)
);

`default_nettype wire
